@@ design/rope_pkg.sv @@
// Shared types, constants and elaboration-time table functions for the
// rotary position embedding core. No dependencies.
`default_nettype none

package rope_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned GUARD_BITS    = 12;
  localparam int unsigned POS_W         = 11;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned ROM_DEPTH     = 2 ** IDX_W;
  localparam int unsigned FREQ_W        = 30;
  localparam int unsigned PHASE_W       = 32;
  localparam int unsigned CORDIC_STAGES = 20;
  localparam int unsigned CORDIC_W      = 32;
  localparam int unsigned GAIN_W        = 31;
  localparam int unsigned PROD_W        = CORDIC_W + GAIN_W;
  localparam int unsigned ROUND_SHIFT   = GUARD_BITS + 30;
  localparam int unsigned WIDE_W        = PROD_W - ROUND_SHIFT;

  // Fixed-point constants of the frequency and angle tables.
  localparam logic [63:0] LOG2_TENK_Q32  = 64'd57070290109;
  localparam logic [63:0] LN2_Q32        = 64'd2977044472;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [63:0] ONE_Q32        = 64'd4294967296;

  // Quadrant codes of the coarse rotation.
  localparam logic [1:0] QUAD_ZERO          = 2'd0;
  localparam logic [1:0] QUAD_QUARTER       = 2'd1;
  localparam logic [1:0] QUAD_HALF          = 2'd2;
  localparam logic [1:0] QUAD_THREE_QUARTER = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [CORDIC_W-1:0]    cordic_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  // Side data that rides along the pipeline for pass-through pairs.
  typedef struct packed {
    logic    pass;
    sample_t a;
    sample_t b;
  } carry_t;

  localparam logic signed [GAIN_W-1:0] INV_GAIN_Q30 = 31'sd652032874;
  localparam prod_t ROUND_HALF = prod_t'(64'd1 << (ROUND_SHIFT - 1));
  localparam wide_t WIDE_MAX   = wide_t'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam wide_t WIDE_MIN   = wide_t'(-(2 ** (SAMPLE_BITS - 1)));

  // Inverse frequency over two pi in Q0.32, from the log2 exponent g in Q.32.
  function automatic logic [63:0] freq_from_g(input logic [63:0] g);
    logic [63:0] n;
    logic [63:0] y;
    logic [63:0] acc;
    logic [63:0] term;
    n    = g >> 32;
    y    = ((g & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
    acc  = ONE_Q32;
    term = ONE_Q32;
    for (int unsigned k = 1; k <= 16; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return (acc * INV_TWO_PI_Q32 + (64'd1 << (31 + n))) >> (32 + n);
  endfunction

  // Arctangent of 2^-i in Q0.32 turns, by its power series.
  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned sh;
    int unsigned d;
    sum = 64'd0;
    if (i == 0) begin
      return 32'h2000_0000;
    end
    for (int unsigned k = 0; i * (2 * k + 1) < 60; k++) begin
      sh = i * (2 * k + 1);
      d  = 2 * k + 1;
      t  = ((64'd1 << 60) >> sh) / 64'(d);
      if (k[0]) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
    end
    t = (((sum >> 28) * INV_TWO_PI_Q32) + (64'd1 << 31)) >> 32;
    return t[31:0];
  endfunction

  // Round half up after the gain product and saturate to the sample range.
  function automatic sample_t round_sat(input prod_t v);
    prod_t r;
    wide_t s;
    r = v + ROUND_HALF;
    s = r[PROD_W-1:ROUND_SHIFT];
    if (s > WIDE_MAX) begin
      s = WIDE_MAX;
    end else if (s < WIDE_MIN) begin
      s = WIDE_MIN;
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/rotary_position_embedding_core.sv @@
// Rotary position embedding core: frequency table, phase multiply, quadrant
// step, pipelined CORDIC and gain compensation. Depends on rope_pkg.
// Throughput: one pair per clock; busy stays low, the pipeline never stalls.
// The depth is set by the 20 CORDIC stages plus five stages for table read,
// phase multiply, quadrant step, gain multiply and rounding.
// Reset clears the valid bits only; no item in flight survives a reset.
`default_nettype none

module rotary_position_embedding_core #(
  parameter int unsigned ROTARY_WIDTH   = 128,
  parameter int unsigned POSITION_LIMIT = 2048
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire signed [rope_pkg::SAMPLE_BITS-1:0] first_half_value_i,
  input  wire signed [rope_pkg::SAMPLE_BITS-1:0] second_half_value_i,
  input  wire        [rope_pkg::POS_W-1:0]       token_position_i,
  input  wire        [rope_pkg::IDX_W-1:0]       pair_index_i,
  output logic                                  done_o,
  output logic signed [rope_pkg::SAMPLE_BITS-1:0] rotated_first_o,
  output logic signed [rope_pkg::SAMPLE_BITS-1:0] rotated_second_o
);

  localparam int unsigned HALF_W  = ROTARY_WIDTH / 2;
  localparam int unsigned NSTG    = rope_pkg::CORDIC_STAGES;
  localparam int unsigned LATENCY = NSTG + 5;
  localparam logic [8:0]  HALF_L  = 9'(HALF_W);
  localparam logic [16:0] MAX_POS_L = 17'(POSITION_LIMIT);
  localparam logic [rope_pkg::POS_W-1:0] POS_LAST = rope_pkg::POS_W'(POSITION_LIMIT - 1);

  // Constant table of inverse frequencies, one entry per pair index.
  logic [rope_pkg::FREQ_W-1:0] freq_tbl [rope_pkg::ROM_DEPTH];

  for (genvar gj = 0; gj < rope_pkg::ROM_DEPTH; gj++) begin : g_rom
    localparam logic [63:0] G =
      (64'(2 * gj) * rope_pkg::LOG2_TENK_Q32) / 64'(ROTARY_WIDTH);
    localparam logic [63:0] F = (gj < HALF_W) ? rope_pkg::freq_from_g(G) : 64'd0;
    assign freq_tbl[gj] = F[rope_pkg::FREQ_W-1:0];
  end

  // The pipeline always advances, so a new item is taken every cycle.
  logic accept;
  logic in_pass;
  logic [rope_pkg::POS_W-1:0] pos_clamped;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign in_pass     = {3'b000, pair_index_i} >= HALF_L;
  assign pos_clamped = ({6'b000000, token_position_i} >= MAX_POS_L) ? POS_LAST
                                                                     : token_position_i;

  // Valid bits and pass-through data travel with every stage.
  logic                    vld_q   [LATENCY];
  rope_pkg::carry_t        carry_q [LATENCY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LATENCY; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k < LATENCY; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q[0] <= '{pass: in_pass, a: first_half_value_i, b: second_half_value_i};
    for (int k = 1; k < LATENCY - 1; k++) begin
      carry_q[k] <= carry_q[k-1];
    end
  end

  // Stage 0: table read and position clamp.
  logic [rope_pkg::FREQ_W-1:0] freq_q;
  logic [rope_pkg::POS_W-1:0]  pos_q;

  always_ff @(posedge clk_i) begin
    freq_q <= freq_tbl[pair_index_i];
    pos_q  <= pos_clamped;
  end

  // Stage 1: phase in turns is the low word of position times frequency.
  logic [rope_pkg::POS_W+rope_pkg::FREQ_W-1:0] phase_full;
  logic [rope_pkg::PHASE_W-1:0]                phase_q;

  assign phase_full = {{rope_pkg::FREQ_W{1'b0}}, pos_q} * {{rope_pkg::POS_W{1'b0}}, freq_q};

  always_ff @(posedge clk_i) begin
    phase_q <= phase_full[rope_pkg::PHASE_W-1:0];
  end

  // Stage 2: coarse rotation by the nearest quarter turn, residual angle to z.
  logic [rope_pkg::PHASE_W-1:0] phase_rnd;
  logic [1:0]                   quad;
  logic [rope_pkg::PHASE_W-1:0] resid;
  rope_pkg::cordic_t            a_ext;
  rope_pkg::cordic_t            b_ext;
  rope_pkg::cordic_t            x_pre;
  rope_pkg::cordic_t            y_pre;

  rope_pkg::cordic_t x_q [NSTG+1];
  rope_pkg::cordic_t y_q [NSTG+1];
  rope_pkg::cordic_t z_q [NSTG+1];

  assign phase_rnd = phase_q + 32'h2000_0000;
  assign quad      = phase_rnd[rope_pkg::PHASE_W-1:rope_pkg::PHASE_W-2];
  assign resid     = phase_q - {quad, 30'd0};
  assign a_ext     = rope_pkg::CORDIC_W'(carry_q[1].a) <<< rope_pkg::GUARD_BITS;
  assign b_ext     = rope_pkg::CORDIC_W'(carry_q[1].b) <<< rope_pkg::GUARD_BITS;

  always_comb begin
    case (quad)
      rope_pkg::QUAD_ZERO: begin
        x_pre = a_ext;
        y_pre = b_ext;
      end
      rope_pkg::QUAD_QUARTER: begin
        x_pre = -b_ext;
        y_pre = a_ext;
      end
      rope_pkg::QUAD_HALF: begin
        x_pre = -a_ext;
        y_pre = -b_ext;
      end
      rope_pkg::QUAD_THREE_QUARTER: begin
        x_pre = b_ext;
        y_pre = -a_ext;
      end
      default: begin
        x_pre = a_ext;
        y_pre = b_ext;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x_pre;
    y_q[0] <= y_pre;
    z_q[0] <= rope_pkg::cordic_t'(resid);
  end

  // CORDIC rotation stages, one micro-rotation per register stage.
  for (genvar gi = 0; gi < NSTG; gi++) begin : g_cordic
    localparam rope_pkg::cordic_t ANG = rope_pkg::cordic_t'(rope_pkg::atan_turns(gi));
    rope_pkg::cordic_t dx;
    rope_pkg::cordic_t dy;

    assign dx = x_q[gi] >>> gi;
    assign dy = y_q[gi] >>> gi;

    always_ff @(posedge clk_i) begin
      if (!z_q[gi][rope_pkg::CORDIC_W-1]) begin
        x_q[gi+1] <= x_q[gi] - dy;
        y_q[gi+1] <= y_q[gi] + dx;
        z_q[gi+1] <= z_q[gi] - ANG;
      end else begin
        x_q[gi+1] <= x_q[gi] + dy;
        y_q[gi+1] <= y_q[gi] - dx;
        z_q[gi+1] <= z_q[gi] + ANG;
      end
    end
  end

  // Gain compensation multiply.
  rope_pkg::prod_t px_q;
  rope_pkg::prod_t py_q;

  always_ff @(posedge clk_i) begin
    px_q <= rope_pkg::prod_t'(x_q[NSTG]) * rope_pkg::prod_t'(rope_pkg::INV_GAIN_Q30);
    py_q <= rope_pkg::prod_t'(y_q[NSTG]) * rope_pkg::prod_t'(rope_pkg::INV_GAIN_Q30);
  end

  // Rounding, saturation and pass-through select into the result register.
  rope_pkg::sample_t rf_q;
  rope_pkg::sample_t rs_q;

  always_ff @(posedge clk_i) begin
    if (carry_q[LATENCY-2].pass) begin
      rf_q <= carry_q[LATENCY-2].a;
      rs_q <= carry_q[LATENCY-2].b;
    end else begin
      rf_q <= rope_pkg::round_sat(px_q);
      rs_q <= rope_pkg::round_sat(py_q);
    end
  end

  assign done_o           = vld_q[LATENCY-1];
  assign rotated_first_o  = rf_q;
  assign rotated_second_o = rs_q;

  // Every transfer in yields exactly one result after the fixed latency.
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted pair produced no result at the expected cycle");

  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching input transfer");

  // The quadrant step leaves at most an eighth of a turn for the CORDIC.
  a_resid_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (z_q[0][31:29] == 3'b000 || z_q[0][31:29] == 3'b111))
    else $error("residual angle outside one eighth of a turn");

  // The CORDIC drives the residual angle close to zero.
  a_resid_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LATENCY-3] |-> (z_q[NSTG][31:13] == '0 || z_q[NSTG][31:13] == '1))
    else $error("CORDIC residual angle did not converge");

  // Pairs beyond half width come out unchanged.
  a_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(accept && in_pass, LATENCY) |->
      rotated_first_o == $past(first_half_value_i, LATENCY) &&
      rotated_second_o == $past(second_half_value_i, LATENCY))
    else $error("pass-through pair was altered");

endmodule

`default_nettype wire
